/* sv/mfd_pkg.sv */
// ----------------------------------------------------------------------------
// mfd_pkg
// Widths, register indexes and limits shared by the feedback decoder files.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int ID_W      = 11;
    localparam int DLC_W     = 4;
    localparam int RAW_ANG_W = 13;
    localparam int ANG_W     = 14;
    localparam int WORD_W    = 16;
    localparam int TEMP_W    = 8;
    localparam int TURN_W    = 18;
    localparam int TOTAL_W   = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTOR_ID       = 8'd0,
        REG_CRITICAL_ANGLE = 8'd1
    } cfg_reg_t;

    localparam logic [ID_W-1:0]      MOTOR_ID_RESET = 11'd514;
    localparam logic [RAW_ANG_W-1:0] CRIT_RESET     = 13'd0;
    localparam logic [DLC_W-1:0]     FRAME_BYTES    = 4'd8;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 18'sd131071;
    localparam logic signed [TURN_W-1:0] TURN_MIN = -18'sd131072;

endpackage

/* sv/cfg_if.sv */
// ----------------------------------------------------------------------------
// cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mfd_pkg::CFG_IDX_W-1:0]     index;
    logic [mfd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/frame_if.sv */
// ----------------------------------------------------------------------------
// frame_if
// Received feedback frame channel with valid/ready.
// ----------------------------------------------------------------------------
interface frame_if;
    logic                                 valid;
    logic                                 ready;
    logic [mfd_pkg::ID_W-1:0]             frame_id;
    logic                                 extended_frame;
    logic                                 remote_frame;
    logic [mfd_pkg::DLC_W-1:0]            data_length;
    logic [mfd_pkg::RAW_ANG_W-1:0]        angle_word;
    logic signed [mfd_pkg::WORD_W-1:0]    speed_word;
    logic signed [mfd_pkg::WORD_W-1:0]    current_word;
    logic [mfd_pkg::TEMP_W-1:0]           temperature_byte;

    modport source (output valid, output frame_id, output extended_frame,
                    output remote_frame, output data_length, output angle_word,
                    output speed_word, output current_word,
                    output temperature_byte, input ready);
    modport sink   (input valid, input frame_id, input extended_frame,
                    input remote_frame, input data_length, input angle_word,
                    input speed_word, input current_word,
                    input temperature_byte, output ready);
endinterface

/* sv/result_if.sv */
// ----------------------------------------------------------------------------
// result_if
// Decoded feedback result channel with valid/ready.
// ----------------------------------------------------------------------------
interface result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 accepted;
    logic [mfd_pkg::ANG_W-1:0]            mapped_angle;
    logic signed [mfd_pkg::WORD_W-1:0]    speed;
    logic signed [mfd_pkg::WORD_W-1:0]    motor_current;
    logic [mfd_pkg::TEMP_W-1:0]           temperature;
    logic signed [mfd_pkg::TOTAL_W-1:0]   total_angle;

    modport source (output valid, output accepted, output mapped_angle,
                    output speed, output motor_current, output temperature,
                    output total_angle, input ready);
    modport sink   (input valid, input accepted, input mapped_angle,
                    input speed, input motor_current, input temperature,
                    input total_angle, output ready);
endinterface

/* sv/motor_feedback_multiturn_decoder.sv */
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder
// Filters motor feedback frames, tracks turns and reports total angle.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   cfg      in   valid/ready   index, data (ready always high)
//   frame    in   valid/ready   frame_id .. temperature_byte
//   result   out  valid/ready   accepted .. total_angle
//
// One item per cycle sustained while result.ready stays high. Two register
// stages: an accepted frame is registered in stage 1, then in the output
// register. Stage 1 does filter, remap and turn update; stage 2 does the
// turn-times-counts multiply and the total sum into the output register.
// Reset clears the tracking state and loads register defaults.
// A stalled result holds both stages; frame.ready drops only while stage 1
// is full behind a stalled result.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder #(
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic            clk,
    input  logic            rst_n,
    cfg_if.sink             cfg,
    frame_if.sink           frame,
    result_if.source        result
);

    localparam int ANG_W  = mfd_pkg::ANG_W;
    localparam int TURN_W = mfd_pkg::TURN_W;
    localparam int PROD_W = 2 * TURN_W;
    localparam logic [ANG_W-1:0]         CPT_ANG = ANG_W'(COUNTS_PER_TURN);
    localparam logic signed [TURN_W-1:0] HALF    = TURN_W'(COUNTS_PER_TURN / 2 - 1);
    localparam logic signed [TURN_W-1:0] CPT_S   = TURN_W'(COUNTS_PER_TURN);

    // configuration
    logic [mfd_pkg::ID_W-1:0]      motor_id_reg;
    logic [mfd_pkg::RAW_ANG_W-1:0] crit_reg;

    // tracking state
    logic                          started_reg;
    logic [ANG_W-1:0]              start_reg;
    logic [ANG_W-1:0]              prev_reg;
    logic signed [TURN_W-1:0]      turn_reg;

    // stage 1
    logic                          s1_valid_reg;
    logic                          s1_acc_reg;
    logic [ANG_W-1:0]              s1_mapped_reg;
    logic signed [mfd_pkg::WORD_W-1:0] s1_speed_reg;
    logic signed [mfd_pkg::WORD_W-1:0] s1_current_reg;
    logic [mfd_pkg::TEMP_W-1:0]    s1_temp_reg;
    logic signed [TURN_W-1:0]      s1_turn_reg;
    logic [ANG_W-1:0]              s1_start_reg;

    // output stage
    logic                          out_valid_reg;
    logic                          out_acc_reg;
    logic [ANG_W-1:0]              out_mapped_reg;
    logic signed [mfd_pkg::WORD_W-1:0] out_speed_reg;
    logic signed [mfd_pkg::WORD_W-1:0] out_current_reg;
    logic [mfd_pkg::TEMP_W-1:0]    out_temp_reg;
    logic signed [mfd_pkg::TOTAL_W-1:0] out_total_reg;

    logic                          frame_fire;
    logic                          hit;
    logic                          lift;
    logic [ANG_W-1:0]              mapped;
    logic [ANG_W-1:0]              prev_eff;
    logic [ANG_W-1:0]              start_next;
    logic signed [TURN_W-1:0]      diff;
    logic signed [TURN_W-1:0]      turn_next;
    logic                          s1_advance;
    logic signed [PROD_W-1:0]      prod;
    logic signed [mfd_pkg::TOTAL_W-1:0] total_next;

    assign cfg.ready   = 1'b1;
    assign s1_advance  = !out_valid_reg || result.ready;
    assign frame.ready = !s1_valid_reg || s1_advance;
    assign frame_fire  = frame.valid && frame.ready;

    assign hit = !frame.extended_frame && !frame.remote_frame
              && (frame.data_length == mfd_pkg::FRAME_BYTES)
              && (frame.frame_id == motor_id_reg);

    assign lift   = (crit_reg != '0) && (frame.angle_word < crit_reg);
    assign mapped = lift ? ({1'b0, frame.angle_word} + CPT_ANG)
                         : {1'b0, frame.angle_word};

    // first frame compares against itself, so no turn is counted
    assign prev_eff   = started_reg ? prev_reg : mapped;
    assign start_next = started_reg ? start_reg : mapped;
    assign diff = $signed({{(TURN_W-ANG_W){1'b0}}, mapped})
                - $signed({{(TURN_W-ANG_W){1'b0}}, prev_eff});

    always_comb
    begin
        turn_next = turn_reg;
        if (diff > HALF)
        begin
            if (turn_reg != mfd_pkg::TURN_MIN)
                turn_next = turn_reg - TURN_W'(1);
        end
        else if (diff < -HALF)
        begin
            if (turn_reg != mfd_pkg::TURN_MAX)
                turn_next = turn_reg + TURN_W'(1);
        end
    end

    assign prod = s1_turn_reg * CPT_S;
    assign total_next = s1_acc_reg
        ? (prod[mfd_pkg::TOTAL_W-1:0]
           + $signed({{(mfd_pkg::TOTAL_W-ANG_W){1'b0}}, s1_mapped_reg})
           - $signed({{(mfd_pkg::TOTAL_W-ANG_W){1'b0}}, s1_start_reg}))
        : '0;

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_id_reg  <= mfd_pkg::MOTOR_ID_RESET;
            crit_reg      <= mfd_pkg::CRIT_RESET;
            started_reg   <= 1'b0;
            start_reg     <= '0;
            prev_reg      <= '0;
            turn_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    mfd_pkg::REG_MOTOR_ID:
                        motor_id_reg <= cfg.data[mfd_pkg::ID_W-1:0];
                    mfd_pkg::REG_CRITICAL_ANGLE:
                        crit_reg <= cfg.data[mfd_pkg::RAW_ANG_W-1:0];
                    default:
                        ;
                endcase
            end

            if (frame_fire && hit)
            begin
                started_reg <= 1'b1;
                start_reg   <= start_next;
                prev_reg    <= mapped;
                turn_reg    <= turn_next;
            end

            if (frame_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (frame_fire)
        begin
            s1_acc_reg     <= hit;
            s1_mapped_reg  <= hit ? mapped : '0;
            s1_speed_reg   <= hit ? frame.speed_word : '0;
            s1_current_reg <= hit ? frame.current_word : '0;
            s1_temp_reg    <= hit ? frame.temperature_byte : '0;
            s1_turn_reg    <= turn_next;
            s1_start_reg   <= start_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_acc_reg     <= s1_acc_reg;
            out_mapped_reg  <= s1_mapped_reg;
            out_speed_reg   <= s1_speed_reg;
            out_current_reg <= s1_current_reg;
            out_temp_reg    <= s1_temp_reg;
            out_total_reg   <= total_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.accepted      = out_acc_reg;
    assign result.mapped_angle  = out_mapped_reg;
    assign result.speed         = out_speed_reg;
    assign result.motor_current = out_current_reg;
    assign result.temperature   = out_temp_reg;
    assign result.total_angle   = out_total_reg;

endmodule

/* sv/mfd_checker.sv */
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks for the feedback decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mfd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 out_accepted,
    input logic [mfd_pkg::ANG_W-1:0]            out_mapped,
    input logic signed [mfd_pkg::WORD_W-1:0]    out_speed,
    input logic signed [mfd_pkg::WORD_W-1:0]    out_current,
    input logic [mfd_pkg::TEMP_W-1:0]           out_temp,
    input logic signed [mfd_pkg::TOTAL_W-1:0]   out_total
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_accepted)
            && $stable(out_mapped) && $stable(out_total))
        else $error("result changed while stalled");

    // rejected frames report all-zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_accepted |-> out_mapped == '0 && out_speed == '0
            && out_current == '0 && out_temp == '0 && out_total == '0)
        else $error("rejected frame with nonzero fields");

    // input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("frame ready low without output stall");

    // a result that follows a drained pipe was preceded by an accepted frame
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid && in_ready) |=> !$rose(out_valid)
            || $past(in_valid && in_ready, 2))
        else $error("result without an accepted frame");

endmodule

bind motor_feedback_multiturn_decoder mfd_checker u_mfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (frame.valid),
    .in_ready     (frame.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_accepted (result.accepted),
    .out_mapped   (result.mapped_angle),
    .out_speed    (result.speed),
    .out_current  (result.motor_current),
    .out_temp     (result.temperature),
    .out_total    (result.total_angle)
);
